// ----- rtl/rks_pkg.sv -----
// Shared types and constants of the streaming Rabin-Karp matcher.
// No dependencies; every other file of the block imports this package.
package rks_pkg;

	// Field and register widths
	localparam int BYTE_W    = 8;
	localparam int Q_W       = 15;
	localparam int PLEN_W    = 5;
	localparam int CFG_W     = 64;
	localparam int ADDR_W    = 5;
	localparam int OUT_W     = 32;
	localparam int PAT_BYTES = 16;

	// Reducer: dividend width and bit counter width
	localparam int RED_W  = BYTE_W + Q_W;
	localparam int RCNT_W = 5;

	// Register reset values
	localparam logic [PLEN_W-1:0] PLEN_RESET = 5'd4;
	localparam logic [Q_W-1:0]    QMOD_RESET = 15'd101;

	// Register map, one 64-bit register every 8 bytes
	typedef enum logic [1:0] {
		REG_PAT_LO = 2'd0,
		REG_PAT_HI = 2'd1,
		REG_PLEN   = 2'd2,
		REG_QMOD   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0]  pat_hi;
		logic [CFG_W-1:0]  pat_lo;
		logic [PLEN_W-1:0] plen;
		logic [Q_W-1:0]    qmod;
	} cfg_t;

	// Operand selection of the shared reducer
	typedef enum logic [2:0] {
		RED_POW  = 3'd0,
		RED_PAT  = 3'd1,
		RED_HASH = 3'd2,
		RED_DROP = 3'd3,
		RED_PUSH = 3'd4
	} red_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     derive_init;
		logic     pow_ld;
		logic     j_clr;
		logic     pat_ld;
		logic     take_byte;
		logic     r1_direct;
		logic     r1_red;
		logic     prod_ld;
		logic     x_from_r1;
		logic     x_sub;
		logic     hash_ld;
		logic     emit;
		logic     red_start;
		red_sel_t red_sel;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic red_idle;
		logic pow_more;
		logic pat_more;
		logic hash_lt_q;
		logic pos_ge_len;
		logic match;
		logic out_full;
	} dp_sts_t;

endpackage

// ----- rtl/rks_in_if.sv -----
// Text byte channel: valid/ready handshake with one text byte per beat.
// Depends on rks_pkg for the byte width.
interface rks_in_if;
	import rks_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              first_of_text;

	modport source (output valid, output text_byte, output first_of_text, input ready);
	modport sink   (input valid, input text_byte, input first_of_text, output ready);

endinterface

// ----- rtl/rks_out_if.sv -----
// Match channel: valid/ready handshake with one match start index per beat.
// Depends on rks_pkg for the index width.
interface rks_out_if;
	import rks_pkg::*;

	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] match_index;

	modport source (output valid, output match_index, input ready);
	modport sink   (input valid, input match_index, output ready);

endinterface

// ----- rtl/rks_regs.sv -----
// APB-style configuration registers of the matcher.
// Depends on rks_pkg for the register map and the cfg_t bundle.
module rks_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [rks_pkg::ADDR_W-1:0] paddr,
	input  logic [rks_pkg::CFG_W-1:0]  pwdata,
	output logic [rks_pkg::CFG_W-1:0]  prdata,
	output logic                      pready,
	output rks_pkg::cfg_t             cfg,
	output logic                      cfg_wr
);
	import rks_pkg::*;

	reg_idx_t idx;
	cfg_t     cfg_q;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Write the addressed register on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pat_lo <= '0;
			cfg_q.pat_hi <= '0;
			cfg_q.plen   <= PLEN_RESET;
			cfg_q.qmod   <= QMOD_RESET;
		end else if (cfg_wr) begin
			unique case (idx)
				REG_PAT_LO: cfg_q.pat_lo <= pwdata;
				REG_PAT_HI: cfg_q.pat_hi <= pwdata;
				REG_PLEN:   cfg_q.plen   <= pwdata[PLEN_W-1:0];
				REG_QMOD:   cfg_q.qmod   <= pwdata[Q_W-1:0];
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (idx)
			REG_PAT_LO: prdata = cfg_q.pat_lo;
			REG_PAT_HI: prdata = cfg_q.pat_hi;
			REG_PLEN:   prdata = CFG_W'(cfg_q.plen);
			REG_QMOD:   prdata = CFG_W'(cfg_q.qmod);
		endcase
	end

endmodule

// ----- rtl/rks_reducer.sv -----
// Bit-serial modulo reducer: one dividend bit per cycle, remainder kept below q.
// Depends on rks_pkg for operand widths.
module rks_reducer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rks_pkg::Q_W-1:0]    init_rem,
	input  logic [rks_pkg::RED_W-1:0]  opnd,
	input  logic [rks_pkg::RCNT_W-1:0] nbits,
	input  logic [rks_pkg::Q_W-1:0]    qmod,
	output logic                       idle,
	output logic [rks_pkg::Q_W-1:0]    rem
);
	import rks_pkg::*;

	logic [Q_W-1:0]    rem_q;
	logic [RED_W-1:0]  opnd_q;
	logic [RCNT_W-1:0] cnt_q;
	logic [Q_W:0]      trial;
	logic [Q_W:0]      next_rem;

	// Shift in the next dividend bit and subtract q once if needed
	always_comb begin
		trial = {rem_q, opnd_q[RED_W-1]};
		if (trial >= {1'b0, qmod})
			next_rem = trial - {1'b0, qmod};
		else
			next_rem = trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= nbits;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - RCNT_W'(1);
		end
	end

	// Load on start, then advance one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= init_rem;
			opnd_q <= opnd;
		end else if (cnt_q != '0) begin
			rem_q  <= next_rem[Q_W-1:0];
			opnd_q <= {opnd_q[RED_W-2:0], 1'b0};
		end
	end

	assign idle = (cnt_q == '0);
	assign rem  = rem_q;

endmodule

// ----- rtl/rks_dp.sv -----
// Datapath of the matcher: window shift line, rolling hash registers, derived
// pattern hash and leading power, match compare and output register.
// Depends on rks_pkg and rks_reducer.
module rks_dp #(
	parameter int MAX_PATTERN = 16,
	parameter int INDEX_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rks_pkg::cfg_t              cfg,
	input  rks_pkg::dp_cmd_t           cmd,
	output rks_pkg::dp_sts_t           sts,
	input  logic [rks_pkg::BYTE_W-1:0] text_byte,
	input  logic                       first_of_text,
	output logic                       hit_valid,
	input  logic                       hit_ready,
	output logic [rks_pkg::OUT_W-1:0]  match_index
);
	import rks_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int WIN_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam logic [INDEX_WIDTH-1:0] IDX_MAX = {INDEX_WIDTH{1'b1}};

	// Effective configuration
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] len_m1;
	logic [Q_W-1:0]   q;

	// Derivation state
	logic [Q_W-1:0]    pow_q;
	logic [Q_W-1:0]    pat_q;
	logic [LEN_W-1:0]  j_q;
	logic [BYTE_W-1:0] pat_al_q [MAX_PATTERN];
	logic [2*CFG_W-1:0] pat_all;
	logic [3:0]        pidx;
	logic [BYTE_W-1:0] pbyte;

	// Per-byte state
	logic [BYTE_W-1:0]      win_q [MAX_PATTERN];
	logic [BYTE_W-1:0]      byte_q;
	logic [BYTE_W-1:0]      old_q;
	logic [INDEX_WIDTH-1:0] cnt_q;
	logic [INDEX_WIDTH-1:0] pos_q;
	logic [Q_W-1:0]         hash_q;
	logic [Q_W-1:0]         r1_q;
	logic [Q_W-1:0]         x_q;
	logic [RED_W-1:0]       prod_q;
	logic [Q_W:0]           x_diff;

	// Reducer hookup
	logic [Q_W-1:0]    red_init;
	logic [RED_W-1:0]  red_opnd;
	logic [RCNT_W-1:0] red_n;
	logic              red_idle;
	logic [Q_W-1:0]    red_rem;

	// Match and output
	logic                   full;
	logic                   bytes_eq;
	logic                   hit_valid_q;
	logic [INDEX_WIDTH-1:0] idx_q;

	// Clamp length and modulus to their working ranges
	always_comb begin
		if (cfg.plen == '0)
			len = LEN_W'(1);
		else if (cfg.plen > PLEN_W'(MAX_PATTERN))
			len = LEN_W'(MAX_PATTERN);
		else
			len = LEN_W'(cfg.plen);
		len_m1 = len - LEN_W'(1);
		q = (cfg.qmod < Q_W'(2)) ? Q_W'(1) : cfg.qmod;
	end

	// Pattern byte j of the configured pattern
	assign pat_all = {cfg.pat_hi, cfg.pat_lo};
	assign pidx    = 4'(j_q);
	assign pbyte   = pat_all[{pidx, 3'b000} +: BYTE_W];

	// Select reducer operands
	always_comb begin
		red_init = '0;
		red_opnd = '0;
		red_n    = '0;
		case (cmd.red_sel)
			RED_POW: begin
				red_init = pow_q;
				red_n    = RCNT_W'(BYTE_W);
			end
			RED_PAT: begin
				red_init = pat_q;
				red_opnd = {pbyte, {(RED_W-BYTE_W){1'b0}}};
				red_n    = RCNT_W'(BYTE_W);
			end
			RED_HASH: begin
				red_opnd = {hash_q, {(RED_W-Q_W){1'b0}}};
				red_n    = RCNT_W'(Q_W);
			end
			RED_DROP: begin
				red_opnd = prod_q;
				red_n    = RCNT_W'(RED_W);
			end
			RED_PUSH: begin
				red_init = x_q;
				red_opnd = {byte_q, {(RED_W-BYTE_W){1'b0}}};
				red_n    = RCNT_W'(BYTE_W);
			end
			default: begin
				red_init = '0;
			end
		endcase
	end

	rks_reducer u_reducer (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.red_start),
		.init_rem (red_init),
		.opnd     (red_opnd),
		.nbits    (red_n),
		.qmod     (q),
		.idle     (red_idle),
		.rem      (red_rem)
	);

	// Derive leading power and pattern hash; build the reversed pattern
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
		end else if (cmd.derive_init || cmd.j_clr) begin
			j_q <= '0;
		end else if (cmd.pow_ld || cmd.pat_ld) begin
			j_q <= j_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.derive_init) begin
			pow_q <= (q == Q_W'(1)) ? '0 : Q_W'(1);
			pat_q <= '0;
		end
		if (cmd.pow_ld)
			pow_q <= red_rem;
		if (cmd.pat_ld) begin
			pat_q       <= red_rem;
			pat_al_q[0] <= pbyte;
			for (int k = 1; k < MAX_PATTERN; k++)
				pat_al_q[k] <= pat_al_q[k-1];
		end
	end

	// Take a byte: shift the window, capture the outgoing byte
	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			byte_q   <= text_byte;
			old_q    <= win_q[len_m1[WIN_W-1:0]];
			win_q[0] <= text_byte;
			for (int k = 1; k < MAX_PATTERN; k++)
				win_q[k] <= win_q[k-1];
		end
	end

	// Text position and rolling hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pos_q  <= '0;
			hash_q <= '0;
		end else if (cmd.take_byte) begin
			if (first_of_text) begin
				cnt_q  <= INDEX_WIDTH'(1);
				pos_q  <= '0;
				hash_q <= '0;
			end else begin
				pos_q <= cnt_q;
				if (cnt_q != IDX_MAX)
					cnt_q <= cnt_q + INDEX_WIDTH'(1);
			end
		end else if (cmd.hash_ld) begin
			hash_q <= red_rem;
		end
	end

	// Remove the outgoing byte: r1 + q - drop, both already below q
	assign x_diff = {1'b0, r1_q} + {1'b0, q} - {1'b0, red_rem};

	always_ff @(posedge clk) begin
		if (cmd.r1_direct)
			r1_q <= hash_q;
		else if (cmd.r1_red)
			r1_q <= red_rem;
		if (cmd.prod_ld)
			prod_q <= RED_W'(old_q) * RED_W'(pow_q);
		if (cmd.x_from_r1)
			x_q <= r1_q;
		else if (cmd.x_sub)
			x_q <= (r1_q >= red_rem) ? (r1_q - red_rem) : x_diff[Q_W-1:0];
	end

	// Compare the window with the reversed pattern, lane by lane
	always_comb begin
		bytes_eq = 1'b1;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if ((LEN_W'(k) < len) && (win_q[k] != pat_al_q[k]))
				bytes_eq = 1'b0;
		end
	end

	assign full = (pos_q >= INDEX_WIDTH'(len_m1));

	// Output register: hold the index until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			hit_valid_q <= 1'b1;
		end else if (hit_ready) begin
			hit_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			idx_q <= (pos_q == IDX_MAX) ? IDX_MAX : (pos_q - INDEX_WIDTH'(len_m1));
	end

	assign hit_valid   = hit_valid_q;
	assign match_index = OUT_W'(idx_q);

	// Status back to the controller
	always_comb begin
		sts.red_idle   = red_idle;
		sts.pow_more   = ({1'b0, j_q} + (LEN_W+1)'(1)) < {1'b0, len};
		sts.pat_more   = (j_q < len);
		sts.hash_lt_q  = (hash_q < q);
		sts.pos_ge_len = (pos_q >= INDEX_WIDTH'(len));
		sts.match      = full && (hash_q == pat_q) && bytes_eq;
		sts.out_full   = hit_valid_q && !hit_ready;
	end

endmodule

// ----- rtl/rks_ctrl.sv -----
// Controller of the matcher: sequences derivation after reset or a register
// write, and the reduction steps for each text byte. Depends on rks_pkg.
module rks_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr,
	input  logic              in_valid,
	output logic              in_ready,
	input  rks_pkg::dp_sts_t  sts,
	output rks_pkg::dp_cmd_t  cmd
);
	import rks_pkg::*;

	typedef enum logic [3:0] {
		D_INIT,
		D_POW,
		D_POW_W,
		D_PAT,
		D_PAT_W,
		IDLE,
		B_HASH,
		B_HASH_W,
		B_DROP,
		B_MUL,
		B_MUL_W,
		B_PUSH,
		B_PUSH_W,
		B_CHECK
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == IDLE);

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.red_sel = RED_POW;
		unique case (state_q)
			D_INIT: begin
				cmd.derive_init = 1'b1;
				state_d         = D_POW;
			end
			D_POW: begin
				if (sts.pow_more) begin
					cmd.red_start = 1'b1;
					cmd.red_sel   = RED_POW;
					state_d       = D_POW_W;
				end else begin
					cmd.j_clr = 1'b1;
					state_d   = D_PAT;
				end
			end
			D_POW_W: begin
				if (sts.red_idle) begin
					cmd.pow_ld = 1'b1;
					state_d    = D_POW;
				end
			end
			D_PAT: begin
				if (sts.pat_more) begin
					cmd.red_start = 1'b1;
					cmd.red_sel   = RED_PAT;
					state_d       = D_PAT_W;
				end else begin
					state_d = IDLE;
				end
			end
			D_PAT_W: begin
				if (sts.red_idle) begin
					cmd.pat_ld = 1'b1;
					state_d    = D_PAT;
				end
			end
			IDLE: begin
				if (in_valid) begin
					cmd.take_byte = 1'b1;
					state_d       = B_HASH;
				end
			end
			B_HASH: begin
				if (sts.hash_lt_q) begin
					cmd.r1_direct = 1'b1;
					state_d       = B_DROP;
				end else begin
					cmd.red_start = 1'b1;
					cmd.red_sel   = RED_HASH;
					state_d       = B_HASH_W;
				end
			end
			B_HASH_W: begin
				if (sts.red_idle) begin
					cmd.r1_red = 1'b1;
					state_d    = B_DROP;
				end
			end
			B_DROP: begin
				if (sts.pos_ge_len) begin
					cmd.prod_ld = 1'b1;
					state_d     = B_MUL;
				end else begin
					cmd.x_from_r1 = 1'b1;
					state_d       = B_PUSH;
				end
			end
			B_MUL: begin
				cmd.red_start = 1'b1;
				cmd.red_sel   = RED_DROP;
				state_d       = B_MUL_W;
			end
			B_MUL_W: begin
				if (sts.red_idle) begin
					cmd.x_sub = 1'b1;
					state_d   = B_PUSH;
				end
			end
			B_PUSH: begin
				cmd.red_start = 1'b1;
				cmd.red_sel   = RED_PUSH;
				state_d       = B_PUSH_W;
			end
			B_PUSH_W: begin
				if (sts.red_idle) begin
					cmd.hash_ld = 1'b1;
					state_d     = B_CHECK;
				end
			end
			B_CHECK: begin
				// Hold a match until the output register is free
				if (!sts.match) begin
					state_d = IDLE;
				end else if (!sts.out_full) begin
					cmd.emit = 1'b1;
					state_d  = IDLE;
				end
			end
		endcase
		// A register write restarts derivation
		if (cfg_wr)
			state_d = D_INIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= D_INIT;
		else
			state_q <= state_d;
	end

endmodule

// ----- rtl/rabin_karp_stream_matcher.sv -----
// Top level of the streaming Rabin-Karp matcher: registers, controller, datapath.
// Depends on rks_pkg, rks_in_if, rks_out_if, rks_regs, rks_ctrl, rks_dp.
//
//   port     kind         payload               direction
//   text     stream sink  text_byte, first_of_text   in
//   hit      stream src   match_index           out
//   apb      config       4 x 64-bit registers  in/out (psel..pready)
//
// Each text byte runs as a sequence of steps on the shared bit-serial reducer,
// and the next byte is not taken until it finishes: reduce the outgoing byte
// times the leading power, then push the new byte, plus control steps (hash
// re-reduced first when needed, the drop step skipped while the window fills).
// After reset and after every register write the block derives the pattern
// hash and leading power byte by byte, with text held off.
// A match result waits in the output register while the next byte is taken;
// a second match stalls the byte sequence until the first beat is taken.
module rabin_karp_stream_matcher #(
	parameter int MAX_PATTERN = 16,
	parameter int INDEX_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rks_in_if.sink                      text,
	rks_out_if.source                   hit,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rks_pkg::ADDR_W-1:0]  paddr,
	input  logic [rks_pkg::CFG_W-1:0]   pwdata,
	output logic [rks_pkg::CFG_W-1:0]   prdata,
	output logic                        pready
);
	import rks_pkg::*;

	cfg_t    cfg;
	logic    cfg_wr;
	dp_cmd_t cmd;
	dp_sts_t sts;

	rks_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr)
	);

	rks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.in_valid (text.valid),
		.in_ready (text.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rks_dp #(
		.MAX_PATTERN (MAX_PATTERN),
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.text_byte     (text.text_byte),
		.first_of_text (text.first_of_text),
		.hit_valid     (hit.valid),
		.hit_ready     (hit.ready),
		.match_index   (hit.match_index)
	);

endmodule

// ----- dv/rabin_karp_stream_matcher_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the streaming Rabin-Karp matcher: random and directed text
// beats, APB register setup, and an in-bench predictor of every match start index.
// Depends on rks_pkg, rks_in_if, rks_out_if and the rabin_karp_stream_matcher RTL.
module rabin_karp_stream_matcher_tb;
	import rks_pkg::*;

	localparam int          TAIL_CYCLES    = 120;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          LONG_HOLD      = 800;
	localparam int unsigned RADIX          = 256;
	localparam logic [OUT_W-1:0] INDEX_MAX = '1;

	typedef struct {
		logic [BYTE_W-1:0] text_byte;
		logic              first_of_text;
		logic              wait_drain;
	} text_beat_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [CFG_W-1:0]  pwdata;
	logic [CFG_W-1:0]  prdata;
	logic              pready;

	rks_in_if  text_ch ();
	rks_out_if hit_ch ();

	rabin_karp_stream_matcher dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_ch),
		.hit     (hit_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Register copies and matcher state of the predictor
	logic [CFG_W-1:0]  pat_lo_cfg;
	logic [CFG_W-1:0]  pat_hi_cfg;
	logic [PLEN_W-1:0] plen_cfg;
	logic [Q_W-1:0]    qmod_cfg;
	logic [BYTE_W-1:0] win_bytes [PAT_BYTES];
	int unsigned       win_hash;
	int unsigned       pat_hash;
	int unsigned       lead_pow;
	longint unsigned   text_count;

	text_beat_t       text_pending_q [$];
	logic [OUT_W-1:0] match_expect_q [$];

	int errors        = 0;
	int results_taken = 0;
	int long_holds    = 0;
	int idle_cycles   = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned used_len();
		if (plen_cfg == '0)
			return 1;
		if (plen_cfg > PAT_BYTES)
			return PAT_BYTES;
		return plen_cfg;
	endfunction

	function automatic int unsigned used_mod();
		return (qmod_cfg < 2) ? 1 : qmod_cfg;
	endfunction

	function automatic logic [BYTE_W-1:0] pattern_at(input int unsigned j);
		if (j < 8)
			return pat_lo_cfg[8*j +: 8];
		return pat_hi_cfg[8*(j-8) +: 8];
	endfunction

	// Recompute pattern hash and 256^(L-1) mod Q from the registers
	function automatic void rederive();
		int unsigned len;
		int unsigned q;
		int unsigned pw;
		int unsigned ph;
		len = used_len();
		q   = used_mod();
		pw  = 1 % q;
		ph  = 0;
		for (int unsigned j = 0; j + 1 < len; j++)
			pw = (pw * RADIX) % q;
		for (int unsigned j = 0; j < len; j++)
			ph = (ph * RADIX + pattern_at(j)) % q;
		lead_pow = pw;
		pat_hash = ph;
	endfunction

	function automatic void clear_window();
		foreach (win_bytes[k])
			win_bytes[k] = '0;
		win_hash   = 0;
		text_count = 0;
	endfunction

	// Roll one text byte into the window and queue the match start index it reveals
	function automatic void scan_text_byte(input logic [BYTE_W-1:0] b, input logic first);
		int unsigned     len;
		int unsigned     q;
		int unsigned     drop;
		int unsigned     x;
		longint unsigned pos;
		logic            bytes_equal;
		if (first)
			clear_window();
		len = used_len();
		q   = used_mod();
		pos = text_count;
		if (pos >= len) begin
			drop     = (win_bytes[len-1] * lead_pow) % q;
			x        = (win_hash % q + q - drop) % q;
			win_hash = (x * RADIX + b) % q;
		end else begin
			win_hash = ((win_hash % q) * RADIX + b) % q;
		end
		for (int k = PAT_BYTES - 1; k > 0; k--)
			win_bytes[k] = win_bytes[k-1];
		win_bytes[0] = b;
		if (text_count < INDEX_MAX)
			text_count++;
		if (pos + 1 >= len && win_hash == pat_hash) begin
			bytes_equal = 1'b1;
			for (int unsigned j = 0; j < len; j++)
				if (win_bytes[len-1-j] != pattern_at(j))
					bytes_equal = 1'b0;
			if (bytes_equal)
				match_expect_q.insert(match_expect_q.size(),
					pos >= INDEX_MAX ? INDEX_MAX : OUT_W'(pos - (len - 1)));
		end
	endfunction

	// Text driver: present queued beats with random gaps, predict on acceptance
	always @(posedge clk or negedge arst_n) begin : text_driver
		text_beat_t  beat;
		int unsigned src_gap;
		int unsigned src_burst;
		if (!arst_n) begin
			text_ch.valid         <= 1'b0;
			text_ch.text_byte     <= '0;
			text_ch.first_of_text <= 1'b0;
			src_gap   = 0;
			src_burst = 0;
		end else begin
			if (text_ch.valid && text_ch.ready)
				scan_text_byte(text_ch.text_byte, text_ch.first_of_text);
			if (text_ch.valid && !text_ch.ready) begin
				// hold the beat until taken
			end else if (src_gap != 0) begin
				src_gap--;
				text_ch.valid <= 1'b0;
			end else if (text_pending_q.size() != 0 &&
					(!text_pending_q[0].wait_drain || match_expect_q.size() == 0)) begin
				beat = text_pending_q.pop_front();
				text_ch.valid         <= 1'b1;
				text_ch.text_byte     <= beat.text_byte;
				text_ch.first_of_text <= beat.first_of_text;
				if (src_burst != 0) begin
					src_burst--;
					src_gap = 0;
				end else begin
					src_gap = $urandom_range(0, 6);
					if ($urandom_range(0, 24) == 0)
						src_burst = $urandom_range(10, 40);
				end
			end else begin
				text_ch.valid <= 1'b0;
			end
		end
	end

	// Match monitor: compare each beat with the oldest expected index, stall at random
	always @(posedge clk or negedge arst_n) begin : match_monitor
		logic [OUT_W-1:0] want;
		int unsigned      sink_hold;
		int unsigned      sink_burst;
		if (!arst_n) begin
			hit_ch.ready <= 1'b0;
			sink_hold  = 0;
			sink_burst = 0;
		end else begin
			if (hit_ch.valid && hit_ch.ready) begin
				results_taken++;
				if (match_expect_q.size() == 0) begin
					errors++;
					$display("%0t: match_index %0d arrived with none expected",
						$time, hit_ch.match_index);
				end else begin
					want = match_expect_q.pop_front();
					if (hit_ch.match_index !== want) begin
						errors++;
						$display("%0t: match_index expected %0d, got %0d",
							$time, want, hit_ch.match_index);
					end
				end
				// back-pressure long enough to fill the block while text keeps coming
				if (long_holds < 3 && results_taken >= 40 + 200 * long_holds &&
						text_pending_q.size() > 30) begin
					long_holds++;
					sink_hold = LONG_HOLD;
				end else if (sink_burst != 0) begin
					sink_burst--;
					sink_hold = 0;
				end else begin
					sink_hold = $urandom_range(0, 6);
					if ($urandom_range(0, 24) == 0)
						sink_burst = $urandom_range(10, 40);
				end
			end
			if (sink_hold != 0) begin
				sink_hold--;
				hit_ch.ready <= 1'b0;
			end else begin
				hit_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run after too long without any beat or register write
	always @(posedge clk) begin
		if (!arst_n || (text_ch.valid && text_ch.ready) || (hit_ch.valid && hit_ch.ready) ||
				(psel && penable && pwrite && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("rabin_karp_stream_matcher regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic apb_write(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(8 * int'(idx));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PAT_LO: pat_lo_cfg = value;
			REG_PAT_HI: pat_hi_cfg = value;
			REG_PLEN:   plen_cfg   = value[PLEN_W-1:0];
			REG_QMOD:   qmod_cfg   = value[Q_W-1:0];
			default: ;
		endcase
		rederive();
	endtask

	task automatic program_matcher(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
			input logic [PLEN_W-1:0] plen, input logic [Q_W-1:0] qmod);
		apb_write(REG_PAT_LO, lo);
		apb_write(REG_PAT_HI, hi);
		apb_write(REG_PLEN, CFG_W'(plen));
		apb_write(REG_QMOD, CFG_W'(qmod));
	endtask

	task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic first, input logic drain);
		text_beat_t beat;
		beat.text_byte     = b;
		beat.first_of_text = first;
		beat.wait_drain    = drain;
		text_pending_q.insert(text_pending_q.size(), beat);
	endtask

	// Wait until every beat is taken and every match is back, then let the block settle
	task automatic let_drain();
		while (text_pending_q.size() != 0 || text_ch.valid || match_expect_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Text mostly built from pattern copies, some corrupted, plus pattern-byte and raw noise
	task automatic queue_text(input int unsigned n, input logic fresh);
		logic [BYTE_W-1:0] chunk [$];
		logic [BYTE_W-1:0] b;
		int unsigned       len;
		int unsigned       made;
		int unsigned       flip;
		logic              first;
		len   = used_len();
		made  = 0;
		first = fresh;
		while (made < n) begin
			chunk.delete();
			case ($urandom_range(0, 9)) inside
				[0:4]: begin
					flip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : len;
					for (int unsigned j = 0; j < len; j++) begin
						b = pattern_at(j);
						if (j == flip)
							b[$urandom_range(0, BYTE_W - 1)] ^= 1'b1;
						chunk.insert(chunk.size(), b);
					end
				end
				[5:7]: begin
					repeat ($urandom_range(1, 4))
						chunk.insert(chunk.size(), pattern_at($urandom_range(0, len - 1)));
				end
				default: chunk.insert(chunk.size(), BYTE_W'($urandom_range(0, 255)));
			endcase
			foreach (chunk[k]) begin
				queue_byte(chunk[k], first || ($urandom_range(0, 79) == 0), made == n / 2);
				first = 1'b0;
				made++;
			end
		end
	endtask

	task automatic run_random_phase(input logic [PLEN_W-1:0] plen, input logic [Q_W-1:0] qmod,
			input int unsigned n_items, input logic fresh, input logic narrow);
		logic [CFG_W-1:0]  lo;
		logic [CFG_W-1:0]  hi;
		logic [BYTE_W-1:0] sym_a;
		logic [BYTE_W-1:0] sym_b;
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		// two-symbol pattern gives self-overlapping matches
		if (narrow) begin
			sym_a = BYTE_W'($urandom);
			sym_b = BYTE_W'($urandom);
			for (int j = 0; j < 8; j++) begin
				lo[8*j +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
				hi[8*j +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
			end
		end
		program_matcher(lo, hi, plen, qmod);
		queue_text(n_items, fresh);
		let_drain();
	endtask

	initial begin : stimulus
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		text_ch.valid         = 1'b0;
		text_ch.text_byte     = '0;
		text_ch.first_of_text = 1'b0;
		hit_ch.ready          = 1'b0;
		arst_n                = 1'b0;
		pat_lo_cfg            = '0;
		pat_hi_cfg            = '0;
		plen_cfg              = PLEN_RESET;
		qmod_cfg              = QMOD_RESET;
		clear_window();
		rederive();
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset setting: four zero bytes, overlapping matches, then byte extremes
		queue_byte(8'h00, 1'b1, 1'b0);
		repeat (4) queue_byte(8'h00, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0);
		queue_byte(8'h80, 1'b0, 1'b0);
		queue_byte(8'h7F, 1'b0, 1'b0);
		let_drain();

		// all-ones pattern at the longest length and the largest modulus
		program_matcher('1, '1, 5'd16, 15'd32767);
		queue_byte(8'hFF, 1'b1, 1'b0);
		repeat (16) queue_byte(8'hFF, 1'b0, 1'b0);
		let_drain();

		// modulus zero acts as one: every hash is zero, bytes alone decide
		run_random_phase(5'd1, 15'd0, 105, 1'b1, 1'b0);
		// length zero acts as one, modulus one
		run_random_phase(5'd0, 15'd1, 105, 1'b1, 1'b1);
		// lengths above sixteen clamp, tiny modulus forces hash collisions
		run_random_phase(5'd31, 15'd2, 105, 1'b1, 1'b1);
		run_random_phase(5'd17, 15'd32767, 105, 1'b1, 1'b0);
		// keep the text running across a register write
		run_random_phase(5'd5, 15'd101, 105, 1'b0, 1'b1);
		repeat (4)
			run_random_phase(PLEN_W'($urandom_range(1, 16)), Q_W'($urandom_range(2, 32767)),
				105, 1'b1, 1'($urandom_range(0, 1)));

		if (errors == 0)
			$display("rabin_karp_stream_matcher regression: pass");
		else
			$display("rabin_karp_stream_matcher regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/rks_pkg.sv
rtl/rks_in_if.sv
rtl/rks_out_if.sv
rtl/rks_regs.sv
rtl/rks_reducer.sv
rtl/rks_dp.sv
rtl/rks_ctrl.sv
rtl/rabin_karp_stream_matcher.sv
dv/rabin_karp_stream_matcher_tb.sv
